// ===== design/brushfire_distance_transform_core_defines.svh =====
// assertion macros for the brushfire distance transform core
// no dependencies; include once per asserting file
`ifndef BRUSHFIRE_DISTANCE_TRANSFORM_CORE_DEFINES_SVH
`define BRUSHFIRE_DISTANCE_TRANSFORM_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define BDT_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define BDT_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define BDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/bdt_pkg.sv =====
// shared types and constants for the brushfire distance transform core
// no dependencies
package bdt_pkg;
    localparam int MaxWidthDef   = 256;
    localparam int MaxHeightDef  = 256;
    localparam int QueueDepthDef = 65536;
    localparam logic [17:0] Unreached = 18'h3FFFF;

    localparam logic [1:0] CmdLoad = 2'd0;
    localparam logic [1:0] CmdRun  = 2'd1;
    localparam logic [1:0] CmdRead = 2'd2;

    localparam logic [1:0] RegWidth  = 2'd0;
    localparam logic [1:0] RegHeight = 2'd1;
    localparam logic [1:0] RegMetric = 2'd2;
    localparam logic [1:0] RegMaxDist = 2'd3;

    localparam logic [1:0] MetricL1 = 2'd0;
    localparam logic [1:0] MetricL2 = 2'd1;

    // one pixel entry: distance, source, reached
    typedef struct packed {
        logic [17:0] dval;
        logic [7:0]  sx;
        logic [7:0]  sy;
        logic        reached;
    } pix_t;
endpackage

// ===== design/brushfire_distance_transform_core.sv =====
// Brushfire distance transform core. Load and read words pass through accept,
// a memory read and a result register; a load writes the pixel memory and
// returns its new contents. A run word first does the column-major scan (one
// read and one write slot per pixel), then, for every dequeued pixel, a queue
// pop, queue data and own entry read, then for each in-image neighbour a
// direction step, read, metric, and compare and write back, and a direction
// step alone for each direction that falls outside the image, then an empty
// queue check, done and result register. There is no clearing pass; never
// written pixels read as garbage.
// depends on bdt_pkg and brushfire_distance_transform_core_defines.svh
`include "brushfire_distance_transform_core_defines.svh"
module brushfire_distance_transform_core #(
    parameter int MAX_WIDTH   = bdt_pkg::MaxWidthDef,
    parameter int MAX_HEIGHT  = bdt_pkg::MaxHeightDef,
    parameter int QUEUE_DEPTH = bdt_pkg::QueueDepthDef
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [7:0]  s_pixel_x,
    input  logic [7:0]  s_pixel_y,
    input  logic        s_is_feature,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [17:0] m_distance_value,
    output logic [7:0]  m_source_x,
    output logic [7:0]  m_source_y,
    output logic        m_reached,
    output logic        m_run_done,
    output logic        m_queue_overflow
);
    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW = XW + YW;
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = QW + 1;
    localparam int DW = ((XW > YW) ? XW : YW) + 1;

    typedef enum logic [13:0] {
        ST_IDLE   = 14'b00000000000001,
        ST_ACC    = 14'b00000000000010,
        ST_RESP   = 14'b00000000000100,
        ST_SCAN_R = 14'b00000000001000,
        ST_SCAN_W = 14'b00000000010000,
        ST_POP    = 14'b00000000100000,
        ST_POP_W  = 14'b00000001000000,
        ST_OWN_W  = 14'b00000010000000,
        ST_NB     = 14'b00000100000000,
        ST_NB_W   = 14'b00001000000000,
        ST_CMP    = 14'b00010000000000,
        ST_MET    = 14'b00100000000000,
        ST_DONE   = 14'b01000000000000,
        ST_OUT    = 14'b10000000000000
    } state_t;

    // pixel memory and pending queue
    bdt_pkg::pix_t pix_mem [2**AW];
    logic [AW-1:0] queue_mem [QUEUE_DEPTH];

    state_t state_reg, state_next;
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic [1:0]  metric_reg;
    logic [16:0] maxd_reg;

    logic [1:0]  cmd_reg;
    logic [7:0]  px_reg, py_reg;
    logic        inside_reg;
    logic [XW-1:0] cx_reg;
    logic [YW-1:0] cy_reg;
    logic [XW-1:0] qx_reg;
    logic [YW-1:0] qy_reg;
    logic [1:0]  dir_reg;
    logic [7:0]  srcx_reg, srcy_reg;
    logic [17:0] metric_val_reg;
    logic [DW-1:0] ddx_reg, ddy_reg;
    logic [QW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic        ovf_reg;
    bdt_pkg::pix_t rd_reg;
    logic [AW-1:0] qrd_reg;

    logic        out_valid_reg;
    bdt_pkg::pix_t out_pix_reg;
    logic        out_done_reg;

    // effective image size
    logic [XW:0] w_eff;
    logic [YW:0] h_eff;
    always_comb begin
        if (width_reg == 9'd0)
            w_eff = (XW+1)'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = (XW+1)'(MAX_WIDTH);
        else
            w_eff = (XW+1)'(width_reg);
        if (height_reg == 9'd0)
            h_eff = (YW+1)'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = (YW+1)'(MAX_HEIGHT);
        else
            h_eff = (YW+1)'(height_reg);
    end

    // neighbour coordinates and validity for the current direction
    logic [XW-1:0] nx;
    logic [YW-1:0] ny;
    logic          nb_ok;
    always_comb begin
        nx = qx_reg;
        ny = qy_reg;
        nb_ok = 1'b0;
        case (dir_reg)
            2'd0: begin
                nx = qx_reg - XW'(1);
                nb_ok = (qx_reg != '0);
            end
            2'd1: begin
                ny = qy_reg - YW'(1);
                nb_ok = (qy_reg != '0);
            end
            2'd2: begin
                nx = qx_reg + XW'(1);
                nb_ok = ((XW+1)'(qx_reg) + (XW+1)'(1)) < w_eff;
            end
            default: begin
                ny = qy_reg + YW'(1);
                nb_ok = ((YW+1)'(qy_reg) + (YW+1)'(1)) < h_eff;
            end
        endcase
    end

    logic [AW-1:0] nb_addr, cur_addr, q_addr;
    assign nb_addr  = {ny, nx};
    assign cur_addr = {cy_reg, cx_reg};
    assign q_addr   = {qy_reg, qx_reg};

    // absolute differences from the source
    logic [DW-1:0] adx, ady;
    always_comb begin
        logic [DW-1:0] a, b;
        a = DW'(nx);
        b = DW'(srcx_reg);
        adx = (a > b) ? a - b : b - a;
        a = DW'(ny);
        b = DW'(srcy_reg);
        ady = (a > b) ? a - b : b - a;
    end

    // metric from registered differences
    logic [17:0] metric_calc;
    always_comb begin
        logic [35:0] sq;
        sq = 36'(ddx_reg) * 36'(ddx_reg) + 36'(ddy_reg) * 36'(ddy_reg);
        if (metric_reg == bdt_pkg::MetricL1)
            metric_calc = 18'(ddx_reg) + 18'(ddy_reg);
        else if (metric_reg == bdt_pkg::MetricL2)
            metric_calc = (sq > 36'h3FFFF) ? 18'h3FFFF : sq[17:0];
        else
            metric_calc = (ddx_reg > ddy_reg) ? 18'(ddx_reg) : 18'(ddy_reg);
    end

    logic take;
    assign take = (metric_val_reg <= 18'(maxd_reg)) && (metric_val_reg < rd_reg.dval);

    // ring tail, wrapped at the queue depth
    logic [QW:0] tail_sum;
    logic [QW-1:0] tail;
    assign tail_sum = (QW+1)'(head_reg) + count_reg[QW:0];
    assign tail = (32'(tail_sum) >= QUEUE_DEPTH) ? QW'(32'(tail_sum) - QUEUE_DEPTH) :
                  tail_sum[QW-1:0];
    logic q_full;
    assign q_full = (count_reg == CW'(QUEUE_DEPTH));

    logic last_y, last_x;
    assign last_y = ((YW+1)'(cy_reg) + (YW+1)'(1)) >= h_eff;
    assign last_x = ((XW+1)'(cx_reg) + (XW+1)'(1)) >= w_eff;

    assign s_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    logic s_fire;
    assign s_fire = s_valid && s_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_fire) state_next = (s_command == bdt_pkg::CmdRun) ? ST_SCAN_R : ST_ACC;
            ST_ACC:    state_next = ST_RESP;
            ST_RESP:   state_next = ST_IDLE;
            ST_SCAN_R: state_next = ST_SCAN_W;
            ST_SCAN_W: state_next = (last_x && last_y) ? ST_POP : ST_SCAN_R;
            ST_POP:    state_next = (count_reg == '0) ? ST_DONE : ST_POP_W;
            ST_POP_W:  state_next = ST_OWN_W;
            ST_OWN_W:  state_next = ST_NB;
            ST_NB:     state_next = nb_ok ? ST_NB_W : ((dir_reg == 2'd3) ? ST_POP : ST_NB);
            ST_NB_W:   state_next = ST_MET;
            ST_MET:    state_next = ST_CMP;
            ST_CMP:    state_next = (dir_reg == 2'd3) ? ST_POP : ST_NB;
            ST_DONE:   state_next = ST_OUT;
            ST_OUT:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // pixel memory port: one access per cycle
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_command == bdt_pkg::CmdLoad && 32'(s_pixel_x) < MAX_WIDTH
                    && 32'(s_pixel_y) < MAX_HEIGHT) begin
                    if (s_is_feature)
                        pix_mem[{YW'(s_pixel_y), XW'(s_pixel_x)}] <=
                            '{dval: '0, sx: s_pixel_x, sy: s_pixel_y, reached: 1'b1};
                    else
                        pix_mem[{YW'(s_pixel_y), XW'(s_pixel_x)}] <=
                            '{dval: bdt_pkg::Unreached, sx: '0, sy: '0, reached: 1'b0};
                end
            end
            ST_ACC:    rd_reg <= pix_mem[{YW'(py_reg), XW'(px_reg)}];
            ST_SCAN_R: rd_reg <= pix_mem[cur_addr];
            ST_SCAN_W: begin
                if (rd_reg.reached && rd_reg.dval == '0)
                    pix_mem[cur_addr] <= '{dval: '0, sx: 8'(cx_reg), sy: 8'(cy_reg),
                                           reached: 1'b1};
                else
                    pix_mem[cur_addr] <= '{dval: bdt_pkg::Unreached, sx: '0, sy: '0,
                                           reached: 1'b0};
            end
            ST_OWN_W:  rd_reg <= pix_mem[q_addr];
            ST_NB_W:   rd_reg <= pix_mem[nb_addr];
            ST_CMP: begin
                if (take)
                    pix_mem[nb_addr] <= '{dval: metric_val_reg, sx: srcx_reg, sy: srcy_reg,
                                          reached: 1'b1};
            end
            default: ;
        endcase
    end

    // queue memory
    always_ff @(posedge aclk) begin
        if (state_reg == ST_POP)
            qrd_reg <= queue_mem[head_reg];
        if (state_reg == ST_SCAN_W && rd_reg.reached && rd_reg.dval == '0 && !q_full)
            queue_mem[tail] <= cur_addr;
        if (state_reg == ST_CMP && take && !q_full)
            queue_mem[tail] <= nb_addr;
    end

    // control and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            width_reg     <= 9'd256;
            height_reg    <= 9'd256;
            metric_reg    <= bdt_pkg::MetricL1;
            maxd_reg      <= 17'h1FFFF;
            head_reg      <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    bdt_pkg::RegWidth:   width_reg  <= cfg_data[8:0];
                    bdt_pkg::RegHeight:  height_reg <= cfg_data[8:0];
                    bdt_pkg::RegMetric:  metric_reg <= cfg_data[1:0];
                    bdt_pkg::RegMaxDist: maxd_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid_reg && m_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        cmd_reg  <= s_command;
                        px_reg   <= s_pixel_x;
                        py_reg   <= s_pixel_y;
                        inside_reg <= (32'(s_pixel_x) < MAX_WIDTH) &&
                                      (32'(s_pixel_y) < MAX_HEIGHT);
                        cx_reg <= '0;
                        cy_reg <= '0;
                        if (s_command == bdt_pkg::CmdRun) begin
                            head_reg  <= '0;
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                        end
                    end
                end
                ST_RESP: begin
                    out_valid_reg <= 1'b1;
                    out_done_reg  <= 1'b0;
                    if ((cmd_reg == bdt_pkg::CmdLoad || cmd_reg == bdt_pkg::CmdRead)
                        && inside_reg)
                        out_pix_reg <= rd_reg;
                    else if (cmd_reg == bdt_pkg::CmdLoad || cmd_reg == bdt_pkg::CmdRead)
                        out_pix_reg <= '{dval: bdt_pkg::Unreached, sx: '0, sy: '0,
                                         reached: 1'b0};
                    else
                        out_pix_reg <= '0;
                end
                ST_SCAN_W: begin
                    if (rd_reg.reached && rd_reg.dval == '0) begin
                        if (q_full) ovf_reg <= 1'b1;
                        else count_reg <= count_reg + CW'(1);
                    end
                    if (last_y) begin
                        cy_reg <= '0;
                        cx_reg <= cx_reg + XW'(1);
                    end else begin
                        cy_reg <= cy_reg + YW'(1);
                    end
                end
                ST_POP: begin
                    if (count_reg != '0) begin
                        head_reg  <= (32'(head_reg) == QUEUE_DEPTH - 1) ? '0 :
                                     head_reg + QW'(1);
                        count_reg <= count_reg - CW'(1);
                    end
                end
                ST_POP_W: begin
                    qx_reg  <= qrd_reg[XW-1:0];
                    qy_reg  <= qrd_reg[AW-1:XW];
                    dir_reg <= 2'd0;
                end
                ST_NB: begin
                    // own entry sits in rd_reg only on the first direction
                    if (dir_reg == 2'd0) begin
                        srcx_reg <= rd_reg.sx;
                        srcy_reg <= rd_reg.sy;
                    end
                    if (!nb_ok) dir_reg <= dir_reg + 2'd1;
                end
                ST_NB_W: begin
                    ddx_reg <= adx;
                    ddy_reg <= ady;
                end
                ST_MET: metric_val_reg <= metric_calc;
                ST_CMP: begin
                    if (take) begin
                        if (q_full) ovf_reg <= 1'b1;
                        else count_reg <= count_reg + CW'(1);
                    end
                    dir_reg <= dir_reg + 2'd1;
                end
                ST_OUT: begin
                    out_valid_reg <= 1'b1;
                    out_done_reg  <= 1'b1;
                    out_pix_reg   <= '0;
                end
                default: ;
            endcase
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_distance_value = out_pix_reg.dval;
    assign m_source_x       = out_pix_reg.sx;
    assign m_source_y       = out_pix_reg.sy;
    assign m_reached        = out_pix_reg.reached;
    assign m_run_done       = out_done_reg;
    assign m_queue_overflow = ovf_reg;

    // checks
    `BDT_ASSERT_IMPL(a_count_bound, aclk, aresetn, count_reg <= CW'(QUEUE_DEPTH), "queue count past depth")
    `BDT_ASSERT_NEXT(a_run_clears_ovf, aclk, aresetn, (s_fire && s_command == bdt_pkg::CmdRun), (!ovf_reg && count_reg == '0), "run did not clear queue")
    `BDT_ASSERT_NEXT(a_out_holds, aclk, aresetn, (out_valid_reg && !m_ready), (out_valid_reg && $stable(out_pix_reg)), "result dropped")
endmodule
